@@ hw/rtl/depth_fog_pixel_blend_defines.svh @@
// ----------------------------------------------------------------------------
// Depth fog pixel blend assertion macros
// Shared concurrent check forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef DEPTH_FOG_PIXEL_BLEND_DEFINES_SVH
`define DEPTH_FOG_PIXEL_BLEND_DEFINES_SVH

// same-cycle implication
`define DFPB_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define DFPB_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

@@ hw/rtl/dfpb_pkg.sv @@
// ----------------------------------------------------------------------------
// Depth fog pixel blend package
// Field widths, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package dfpb_pkg;

  localparam int PIX_W     = 32;
  localparam int WORD_W    = 32;
  localparam int DEPTH_W   = 25;
  localparam int ALPHA_W   = 8;
  localparam int LANES     = 4;
  localparam int LANE_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = WORD_W + DEPTH_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOG_ON      = 3'd0,
    CFG_NEAR        = 3'd1,
    CFG_FOG_START   = 3'd2,
    CFG_CLEAR_DEPTH = 3'd3,
    CFG_FOG_RGBA    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic               fog_on;
    logic [WORD_W-1:0]  near_scaled;
    logic [WORD_W-1:0]  fog_start_scaled;
    logic [DEPTH_W-1:0] clear_depth;
    logic [WORD_W-1:0]  fog_rgba;
  } cfg_t;

endpackage

@@ hw/rtl/dfpb_alpha.sv @@
// ----------------------------------------------------------------------------
// Fog factor pipeline
// Seven stages: multiply, subtract, then a restoring quotient of 8 bits with
// saturation, up to two bits per stage, carrying the pixel alongside.
// ----------------------------------------------------------------------------
`include "depth_fog_pixel_blend_defines.svh"

module dfpb_alpha #(
  parameter int DEPTH_FRAC_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dfpb_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dfpb_pkg::PIX_W-1:0]     pixel_in,
  input  logic [dfpb_pkg::DEPTH_W-1:0]   depth_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dfpb_pkg::PIX_W-1:0]     pixel,
  output logic                           blend,
  output logic [dfpb_pkg::ALPHA_W-1:0]   alpha
);
  import dfpb_pkg::*;

  localparam int NSTG   = 7;
  localparam int NUM_W  = WORD_W + DEPTH_FRAC_BITS;
  localparam int X_W    = (NUM_W > PROD_W) ? NUM_W : PROD_W;
  localparam int DIFF_W = X_W + 1;

  typedef struct packed {
    logic           q;
    logic [X_W-1:0] r;
  } step_t;

  function automatic step_t div_step(logic [X_W-1:0] x, logic [DEPTH_W-1:0] d,
                                     int unsigned sh);
    logic [X_W-1:0] dv;
    step_t          s;
    dv = X_W'(d) << sh;
    if (x >= dv) begin
      s.q = 1'b1;
      s.r = x - dv;
    end else begin
      s.q = 1'b0;
      s.r = x;
    end
    return s;
  endfunction

  logic [NSTG:1]      v;
  logic [NSTG+1:1]    en;
  logic [PIX_W-1:0]   pix_s   [1:NSTG];
  logic               blend_s [1:NSTG];
  logic [DEPTH_W-1:0] d_s     [1:NSTG-1];

  logic [PROD_W-1:0]  prod1;
  logic [X_W-1:0]     x2, x3, x4, x5, x6;
  logic               neg2, neg3, neg4, neg5, neg6;
  logic               sat3, sat4, sat5, sat6;
  logic [ALPHA_W-1:0] q3, q4, q5, q6;
  logic [ALPHA_W-1:0] alpha7;

  logic [NUM_W-1:0]   num;
  logic [DIFF_W-1:0]  diff;
  step_t              s7, s6, s5, s4, s3, s2, s1, s0;

  always_comb begin
    en[NSTG+1] = out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[1];

  always_comb begin
    num  = {cfg.near_scaled, {DEPTH_FRAC_BITS{1'b0}}};
    diff = DIFF_W'(num) - DIFF_W'(prod1);
    s7   = div_step(x2, d_s[2], 15);
    s6   = div_step(x3, d_s[3], 14);
    s5   = div_step(s6.r, d_s[3], 13);
    s4   = div_step(x4, d_s[4], 12);
    s3   = div_step(s4.r, d_s[4], 11);
    s2   = div_step(x5, d_s[5], 10);
    s1   = div_step(s2.r, d_s[5], 9);
    s0   = div_step(x6, d_s[6], 8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pix_s[1]   <= pixel_in;
      blend_s[1] <= cfg.fog_on && (depth_in > cfg.clear_depth);
      d_s[1]     <= depth_in;
      prod1      <= PROD_W'(cfg.fog_start_scaled) * PROD_W'(depth_in);
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (en[k]) begin
        pix_s[k]   <= pix_s[k-1];
        blend_s[k] <= blend_s[k-1];
      end
    end
    for (int k = 2; k <= NSTG - 1; k++) begin
      if (en[k]) begin
        d_s[k] <= d_s[k-1];
      end
    end
    if (en[2]) begin
      neg2 <= diff[DIFF_W-1];
      x2   <= diff[X_W-1:0];
    end
    if (en[3]) begin
      neg3 <= neg2;
      sat3 <= x2 >= (X_W'(d_s[2]) << 16);
      q3   <= {s7.q, 7'b0};
      x3   <= s7.r;
    end
    if (en[4]) begin
      neg4 <= neg3;
      sat4 <= sat3;
      q4   <= {q3[7], s6.q, s5.q, 5'b0};
      x4   <= s5.r;
    end
    if (en[5]) begin
      neg5 <= neg4;
      sat5 <= sat4;
      q5   <= {q4[7:5], s4.q, s3.q, 3'b0};
      x5   <= s3.r;
    end
    if (en[6]) begin
      neg6 <= neg5;
      sat6 <= sat5;
      q6   <= {q5[7:3], s2.q, s1.q, 1'b0};
      x6   <= s1.r;
    end
    if (en[7]) begin
      if (neg6) begin
        alpha7 <= '0;
      end else if (sat6) begin
        alpha7 <= '1;
      end else begin
        alpha7 <= {q6[7:1], s0.q};
      end
    end
  end

  assign out_valid = v[NSTG];
  assign pixel     = pix_s[NSTG];
  assign blend     = blend_s[NSTG];
  assign alpha     = alpha7;

  `DFPB_ASSERT_NEXT(a_neg_zero, v[6] && en[7] && neg6, alpha7 == '0, "negative factor not zero")
  `DFPB_ASSERT_NEXT(a_sat_full, v[6] && en[7] && !neg6 && sat6, alpha7 == '1, "saturation lost")
  `DFPB_ASSERT_NOW(a_rem_bound, v[3] && !neg3 && !sat3, x3 < (X_W'(d_s[3]) << 15), "remainder out of range")
  `DFPB_ASSERT_NEXT(a_hold, v[NSTG] && !out_ready, v[NSTG] && $stable(alpha7), "stalled factor moved")

endmodule

@@ hw/rtl/depth_fog_pixel_blend.sv @@
// ----------------------------------------------------------------------------
// Depth fog pixel blend
// Linear depth fog applied to a stream of pixels with their depth values.
// ----------------------------------------------------------------------------
// One pixel is taken every cycle while in_ready is high. It passes the fog
// factor pipeline (a 32x25 multiply, a wide subtract, and a restoring
// quotient resolved up to two bits per stage), then the lane blend in the
// output register. Stalls on the output fill bubbles first, so input keeps
// moving while a result waits. Configuration writes are always taken
// (cfg_ready is high) and must be made while no pixel is in flight.
module depth_fog_pixel_blend #(
  parameter int DEPTH_FRAC_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dfpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dfpb_pkg::WORD_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dfpb_pkg::PIX_W-1:0]       pixel_in,
  input  logic [dfpb_pkg::DEPTH_W-1:0]     depth_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dfpb_pkg::PIX_W-1:0]       pixel_out,
  output logic                             written
);
  import dfpb_pkg::*;

  cfg_t               cfg;
  logic               a_valid;
  logic               a_ready;
  logic [PIX_W-1:0]   a_pixel;
  logic               a_blend;
  logic [ALPHA_W-1:0] a_alpha;
  logic [PIX_W-1:0]   blended;
  logic               out_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FOG_ON:      cfg.fog_on           <= cfg_data[0];
        CFG_NEAR:        cfg.near_scaled      <= cfg_data;
        CFG_FOG_START:   cfg.fog_start_scaled <= cfg_data;
        CFG_CLEAR_DEPTH: cfg.clear_depth      <= cfg_data[DEPTH_W-1:0];
        CFG_FOG_RGBA:    cfg.fog_rgba         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dfpb_alpha #(
    .DEPTH_FRAC_BITS(DEPTH_FRAC_BITS)
  ) u_alpha (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .depth_in  (depth_in),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .pixel     (a_pixel),
    .blend     (a_blend),
    .alpha     (a_alpha)
  );

  always_comb begin
    logic [2*LANE_W-1:0] acc;
    logic [LANE_W-1:0]   inv;
    inv = 8'hFF - a_alpha;
    for (int i = 0; i < LANES; i++) begin
      acc = 16'(cfg.fog_rgba[LANE_W*i +: LANE_W]) * 16'(a_alpha)
          + 16'(a_pixel[LANE_W*i +: LANE_W]) * 16'(inv);
      blended[LANE_W*i +: LANE_W] = acc[2*LANE_W-1:LANE_W];
    end
  end

  assign out_en  = !out_valid || out_ready;
  assign a_ready = out_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      pixel_out <= a_blend ? blended : a_pixel;
      written   <= a_blend;
    end
  end

endmodule
